// ===== src/lfs_pkg.sv =====
package lfs_pkg;

	// Register indexes of the configuration port
	localparam logic REG_FULL_COMPARE = 1'b0;
	localparam logic REG_MISS_LIMIT   = 1'b1;

	// Reset values of the configuration registers
	localparam logic [15:0] FULL_RESET  = 16'd18746;
	localparam logic [3:0]  LIMIT_RESET = 4'd10;

	// Side codes of the last-side memory
	localparam logic [1:0] SIDE_RIGHT = 2'd0;
	localparam logic [1:0] SIDE_LEFT  = 2'd1;
	localparam logic [1:0] SIDE_NONE  = 2'd3;

	// Sensor priority classes
	localparam logic [4:0] MASK_EDGE_RIGHT = 5'h01;
	localparam logic [4:0] MASK_CENTRE     = 5'h06;
	localparam logic [4:0] MASK_LEFT       = 5'h18;

	// Reciprocal multipliers: x/5 = (x*MUL5)>>18, x/7 = (x*MUL7)>>19 for any 16-bit x
	localparam logic [15:0] MUL5   = 16'd52429;
	localparam int          SHIFT5 = 18;
	localparam logic [16:0] MUL7   = 17'd74899;
	localparam int          SHIFT7 = 19;

	// Step fractions of the reset full value
	localparam logic [15:0] F4_RESET  = 16'(FULL_RESET / 4);
	localparam logic [15:0] F5_RESET  = 16'(FULL_RESET / 5);
	localparam logic [15:0] F7_RESET  = 16'(FULL_RESET / 7);
	localparam logic [15:0] F10_RESET = 16'(FULL_RESET / 10);

	typedef struct packed {
		logic [15:0] f4;
		logic [15:0] f5;
		logic [15:0] f7;
		logic [15:0] f10;
	} frac_t;

	typedef struct packed {
		logic [15:0] right_duty;
		logic [15:0] left_duty;
		logic [1:0]  last_side;
		logic        seek_pending;
		logic        recover_pending;
		logic [3:0]  miss_count;
	} steer_state_t;

endpackage

// ===== src/line_follow_steering_unit.sv =====
// Channel   | Signals                                        | Direction
// sensor    | sensor_valid, sensor_ready, sensor_bits        | request in
// result    | result_valid, result_ready, right_compare,     | request out
//           | left_compare, sensor_pattern                   |
// config    | cfg_we, cfg_index, cfg_data                    | write in
//
// A request is registered in the input stage on acceptance and its result is registered in the
// result stage as it advances; one request is taken every cycle unless the result stalls or a refresh runs.
// The steering state is updated in the same cycle the result is registered.
// After a configuration write the sensor port holds ready low while the
// step fractions are recomputed by the reciprocal multipliers.
// A stalled result holds the input stage; ready falls only when both are full, or during a refresh.
// Reset is asynchronous and restores the duties and registers to their reset values.
module line_follow_steering_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sensor_valid,
	output logic        sensor_ready,
	input  logic [4:0]  sensor_bits,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] right_compare,
	output logic [15:0] left_compare,
	output logic [4:0]  sensor_pattern,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import lfs_pkg::*;

	logic [15:0]  full_compare_q;
	logic [3:0]   miss_limit_q;
	logic         refresh_q;
	frac_t        frac;
	logic [4:0]   sensor_s1;
	logic         valid_s1;
	logic         advance;
	steer_state_t state_q;
	steer_state_t state_next;
	logic         valid_s2;
	logic [15:0]  right_s2;
	logic [15:0]  left_s2;
	logic [4:0]   pattern_s2;

	// Configuration registers; any write triggers a fraction refresh
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_compare_q <= FULL_RESET;
			miss_limit_q   <= LIMIT_RESET;
			refresh_q      <= 1'b0;
		end else begin
			refresh_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					REG_FULL_COMPARE: full_compare_q <= cfg_data;
					REG_MISS_LIMIT:   miss_limit_q   <= cfg_data[3:0];
					default:          ;
				endcase
			end
		end
	end

	lfs_frac u_frac (
		.clk          (clk),
		.arst_n       (arst_n),
		.refresh      (refresh_q),
		.full_compare (full_compare_q),
		.frac         (frac)
	);

	// Handshake control of the two stages
	assign advance      = valid_s1 && (!valid_s2 || result_ready);
	assign sensor_ready = !refresh_q && (!valid_s1 || advance);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor_valid && sensor_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor_valid && sensor_ready) begin
			sensor_s1 <= sensor_bits;
		end
	end

	lfs_core u_core (
		.sensor       (sensor_s1),
		.cur          (state_q),
		.frac         (frac),
		.full_compare (full_compare_q),
		.miss_limit   (miss_limit_q),
		.nxt          (state_next)
	);

	// Steering state, updated as each request moves into the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.right_duty      <= FULL_RESET;
			state_q.left_duty       <= FULL_RESET;
			state_q.last_side       <= SIDE_NONE;
			state_q.seek_pending    <= 1'b0;
			state_q.recover_pending <= 1'b0;
			state_q.miss_count      <= 4'd0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			right_s2   <= state_next.right_duty;
			left_s2    <= state_next.left_duty;
			pattern_s2 <= sensor_s1;
		end
	end

	assign result_valid   = valid_s2;
	assign right_compare  = right_s2;
	assign left_compare   = left_s2;
	assign sensor_pattern = pattern_s2;

endmodule

// ===== src/lfs_frac.sv =====
module lfs_frac (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             refresh,
	input  logic [15:0]      full_compare,
	output lfs_pkg::frac_t   frac
);
	import lfs_pkg::*;

	logic [31:0] prod5;
	logic [32:0] prod7;
	frac_t       frac_q;

	// Divide the full value by five and seven through reciprocal products
	assign prod5 = 32'(full_compare) * 32'(MUL5);
	assign prod7 = 33'(full_compare) * 33'(MUL7);

	// Fractions are recomputed the cycle after a configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q.f4  <= F4_RESET;
			frac_q.f5  <= F5_RESET;
			frac_q.f7  <= F7_RESET;
			frac_q.f10 <= F10_RESET;
		end else if (refresh) begin
			frac_q.f4  <= {2'b00, full_compare[15:2]};
			frac_q.f5  <= 16'(prod5 >> SHIFT5);
			frac_q.f7  <= 16'(prod7 >> SHIFT7);
			frac_q.f10 <= 16'(prod5 >> (SHIFT5 + 1));
		end
	end

	assign frac = frac_q;

endmodule

// ===== src/lfs_core.sv =====
module lfs_core (
	input  logic [4:0]            sensor,
	input  lfs_pkg::steer_state_t cur,
	input  lfs_pkg::frac_t        frac,
	input  logic [15:0]           full_compare,
	input  logic [3:0]            miss_limit,
	output lfs_pkg::steer_state_t nxt
);
	import lfs_pkg::*;

	logic [15:0] right_base;
	logic [15:0] left_base;
	logic [3:0]  miss_inc;

	// Decode the sample by priority and work out the next steering state
	always_comb begin
		nxt        = cur;
		right_base = cur.right_duty;
		left_base  = cur.left_duty;
		miss_inc   = cur.miss_count + 4'd1;

		if ((sensor & MASK_EDGE_RIGHT) != 5'd0) begin
			nxt.last_side = SIDE_RIGHT;
			if (cur.seek_pending) begin
				// Line found again after seeking: hard correction, arm recovery
				nxt.right_duty      = full_compare;
				nxt.left_duty       = cur.left_duty - frac.f4;
				nxt.seek_pending    = 1'b0;
				nxt.recover_pending = 1'b1;
			end else begin
				nxt.right_duty = cur.right_duty - frac.f7;
				nxt.left_duty  = cur.left_duty + frac.f7;
				nxt.miss_count = 4'd0;
			end
		end else if ((sensor & MASK_CENTRE) != 5'd0) begin
			if (cur.recover_pending) begin
				right_base = full_compare;
				left_base  = cur.left_duty - frac.f4;
			end
			nxt.recover_pending = 1'b0;
			nxt.last_side       = SIDE_RIGHT;
			nxt.miss_count      = 4'd0;
			nxt.right_duty      = right_base - frac.f10;
			nxt.left_duty       = left_base + frac.f10;
		end else if ((sensor & MASK_LEFT) != 5'd0) begin
			if (cur.recover_pending) begin
				right_base = cur.right_duty - frac.f4;
				left_base  = full_compare;
			end
			nxt.recover_pending = 1'b0;
			nxt.last_side       = SIDE_LEFT;
			nxt.miss_count      = 4'd0;
			nxt.right_duty      = right_base + frac.f10;
			nxt.left_duty       = left_base - frac.f10;
		end else begin
			// Line lost: count misses and keep turning towards the last side
			if (miss_inc == miss_limit) begin
				nxt.seek_pending = 1'b1;
				nxt.miss_count   = 4'd0;
			end else begin
				nxt.miss_count = miss_inc;
			end
			if (cur.last_side == SIDE_LEFT) begin
				nxt.right_duty = cur.right_duty + frac.f5;
				nxt.left_duty  = cur.left_duty - frac.f5;
			end else if (cur.last_side == SIDE_RIGHT) begin
				nxt.right_duty = cur.right_duty - frac.f5;
				nxt.left_duty  = cur.left_duty + frac.f5;
			end
		end
	end

endmodule

// ===== src/lfs_checker.sv =====
module lfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sensor_valid,
	input logic        sensor_ready,
	input logic [4:0]  sensor_bits,
	input logic        result_valid,
	input logic        result_ready,
	input logic [15:0] right_compare,
	input logic [15:0] left_compare,
	input logic [4:0]  sensor_pattern,
	input logic        cfg_we
);

	// A waiting request keeps its valid and its sensor bits
	assert property (@(posedge clk) disable iff (!arst_n)
		sensor_valid && !sensor_ready |=> sensor_valid && $stable(sensor_bits))
	else $error("waiting request changed");

	// A stalled result holds its values
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(right_compare) && $stable(left_compare)
			&& $stable(sensor_pattern))
	else $error("stalled result changed");

	// The cycle after a configuration write takes no request
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !sensor_ready)
	else $error("request taken while fractions refresh");

	// With the result stage empty and no refresh, the block is always ready
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !$past(cfg_we) |-> sensor_ready)
	else $error("ready low with empty result stage");

endmodule

bind line_follow_steering_unit lfs_checker u_lfs_checker (.*);

// ===== test/line_follow_steering_unit_tb.sv =====
`timescale 1ns / 1ps

module line_follow_steering_unit_tb;
	import lfs_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int IDLE_LIMIT    = 200;
	localparam int PHASE_ITEMS   = 80;
	localparam int PHASE_COUNT   = 8;

	typedef struct packed {
		logic [15:0] right;
		logic [15:0] left;
		logic [4:0]  pattern;
	} compare_rec_t;

	typedef struct {
		logic [4:0]  bits;
		bit          typed;
		logic [15:0] right;
		logic [15:0] left;
	} sample_row_t;

	logic        clk;
	logic        arst_n;
	logic        sensor_valid;
	logic        sensor_ready;
	logic [4:0]  sensor_bits;
	logic        result_valid;
	logic        result_ready;
	logic [15:0] right_compare;
	logic [15:0] left_compare;
	logic [4:0]  sensor_pattern;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	// Predictor copy of the steering state and the two registers
	steer_state_t steer_now;
	logic [15:0]  full_now;
	logic [3:0]   limit_now;

	compare_rec_t pending_compares[$];
	int           fail_count;
	int           idle_cycles;
	int           rx_hold;
	bit           quiet;

	line_follow_steering_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sensor_valid   (sensor_valid),
		.sensor_ready   (sensor_ready),
		.sensor_bits    (sensor_bits),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.right_compare  (right_compare),
		.left_compare   (left_compare),
		.sensor_pattern (sensor_pattern),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the compare values that one sensor sample leads to.
	task automatic steer_predict(input logic [4:0] bits, output compare_rec_t rec);
		logic [15:0] f4, f5, f7, f10;
		f4  = full_now / 4;
		f5  = full_now / 5;
		f7  = full_now / 7;
		f10 = full_now / 10;
		if (bits & MASK_EDGE_RIGHT) begin
			steer_now.last_side = SIDE_RIGHT;
			if (steer_now.seek_pending) begin
				steer_now.right_duty      = full_now;
				steer_now.left_duty       = steer_now.left_duty - f4;
				steer_now.seek_pending    = 1'b0;
				steer_now.recover_pending = 1'b1;
			end else begin
				steer_now.right_duty = steer_now.right_duty - f7;
				steer_now.left_duty  = steer_now.left_duty + f7;
				steer_now.miss_count = '0;
			end
		end else if (bits & MASK_CENTRE) begin
			if (steer_now.recover_pending) begin
				steer_now.right_duty      = full_now;
				steer_now.left_duty       = steer_now.left_duty - f4;
				steer_now.recover_pending = 1'b0;
			end
			steer_now.last_side  = SIDE_RIGHT;
			steer_now.miss_count = '0;
			steer_now.right_duty = steer_now.right_duty - f10;
			steer_now.left_duty  = steer_now.left_duty + f10;
		end else if (bits & MASK_LEFT) begin
			if (steer_now.recover_pending) begin
				steer_now.right_duty      = steer_now.right_duty - f4;
				steer_now.left_duty       = full_now;
				steer_now.recover_pending = 1'b0;
			end
			steer_now.last_side  = SIDE_LEFT;
			steer_now.miss_count = '0;
			steer_now.right_duty = steer_now.right_duty + f10;
			steer_now.left_duty  = steer_now.left_duty - f10;
		end else begin
			// Line lost: count the miss and keep turning towards the last side.
			steer_now.miss_count = steer_now.miss_count + 4'd1;
			if (steer_now.miss_count == limit_now) begin
				steer_now.seek_pending = 1'b1;
				steer_now.miss_count   = '0;
			end
			if (steer_now.last_side == SIDE_LEFT) begin
				steer_now.right_duty = steer_now.right_duty + f5;
				steer_now.left_duty  = steer_now.left_duty - f5;
			end else if (steer_now.last_side == SIDE_RIGHT) begin
				steer_now.right_duty = steer_now.right_duty - f5;
				steer_now.left_duty  = steer_now.left_duty + f5;
			end
		end
		rec.right   = steer_now.right_duty;
		rec.left    = steer_now.left_duty;
		rec.pattern = bits;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= 40)
			$display("%0d ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
	endtask

	// Sends one sensor request; entered and left at a falling edge with valid still high.
	task automatic send_sample(input logic [4:0] bits, input int gap, input bit typed,
			input logic [15:0] want_right, input logic [15:0] want_left);
		compare_rec_t rec;
		if (gap > 0) begin
			sensor_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sensor_valid <= 1'b1;
		sensor_bits  <= bits;
		do @(posedge clk); while (!sensor_ready);
		steer_predict(bits, rec);
		if (typed) begin
			rec.right = want_right;
			rec.left  = want_left;
		end
		pending_compares.push_back(rec);
		@(negedge clk);
	endtask

	// Stops sending and waits until every outstanding result has come back.
	task automatic hold_until_drained();
		sensor_valid <= 1'b0;
		while (pending_compares.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes both registers on back-to-back cycles while the block is idle.
	task automatic write_settings(input logic [15:0] full_word, input logic [15:0] limit_word);
		hold_until_drained();
		cfg_we    <= 1'b1;
		cfg_index <= REG_FULL_COMPARE;
		cfg_data  <= full_word;
		@(negedge clk);
		cfg_index <= REG_MISS_LIMIT;
		cfg_data  <= limit_word;
		@(negedge clk);
		cfg_we <= 1'b0;
		full_now  = full_word;
		limit_now = limit_word[3:0];
	endtask

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 5);
	endfunction

	// Result side: stall the channel for a drawn number of cycles after each result.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			result_ready <= 1'b0;
			rx_hold--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Compare each returned result with the oldest expectation.
	always @(posedge clk) begin
		compare_rec_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_compares.size() == 0) begin
				report_mismatch("unexpected result, right_compare", right_compare, 0);
			end else begin
				want = pending_compares.pop_front();
				if (right_compare !== want.right)
					report_mismatch("right_compare", right_compare, want.right);
				if (left_compare !== want.left)
					report_mismatch("left_compare", left_compare, want.left);
				if (sensor_pattern !== want.pattern)
					report_mismatch("sensor_pattern", sensor_pattern, want.pattern);
			end
			rx_hold = quiet ? 0 : $urandom_range(0, 5);
		end
	end

	// Watchdog on cycles where nothing moves on any port.
	always @(posedge clk) begin
		if (!arst_n || (sensor_valid && sensor_ready) || (result_valid && result_ready) ||
				cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		sample_row_t opening[$];
		logic [15:0] full_words[PHASE_COUNT];
		logic [15:0] limit_words[PHASE_COUNT];
		logic [4:0]  bits;
		int          zero_run;
		int          pick;

		// Directed rows: the two typed ones follow straight from the reset values.
		opening = '{
			'{5'h00, 1'b1, 16'd18746, 16'd18746},
			'{5'h01, 1'b1, 16'd16068, 16'd21424},
			'{5'h02, 1'b0, 16'd0, 16'd0},
			'{5'h04, 1'b0, 16'd0, 16'd0},
			'{5'h06, 1'b0, 16'd0, 16'd0},
			'{5'h08, 1'b0, 16'd0, 16'd0},
			'{5'h10, 1'b0, 16'd0, 16'd0},
			'{5'h18, 1'b0, 16'd0, 16'd0},
			'{5'h1F, 1'b0, 16'd0, 16'd0},
			'{5'h11, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h01, 1'b0, 16'd0, 16'd0},
			'{5'h18, 1'b0, 16'd0, 16'd0},
			'{5'h00, 1'b0, 16'd0, 16'd0},
			'{5'h08, 1'b0, 16'd0, 16'd0}
		};

		// Register settings per phase: extremes first, then random ones mixed with one extreme, then the reset values.
		full_words  = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0004,
			16'($urandom), 16'hFFFF, 16'($urandom), FULL_RESET};
		limit_words = '{16'hFFFF, 16'h0001, 16'h0000, 16'hFFF1,
			16'($urandom), 16'h0002, 16'($urandom), 16'(LIMIT_RESET)};

		arst_n       = 1'b0;
		sensor_valid = 1'b0;
		sensor_bits  = '0;
		result_ready = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_FULL_COMPARE;
		cfg_data     = '0;
		fail_count   = 0;
		idle_cycles  = 0;
		rx_hold      = 0;
		quiet        = 1'b0;

		full_now  = FULL_RESET;
		limit_now = LIMIT_RESET;
		steer_now = '{right_duty: FULL_RESET, left_duty: FULL_RESET, last_side: SIDE_NONE,
			seek_pending: 1'b0, recover_pending: 1'b0, miss_count: 4'd0};

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part with the reset settings.
		foreach (opening[i])
			send_sample(opening[i].bits, draw_gap(), opening[i].typed,
				opening[i].right, opening[i].left);

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			write_settings(full_words[ph], limit_words[ph]);
			quiet    = (ph == 1) || ($urandom_range(0, 3) == 0);
			zero_run = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (zero_run > 0) begin
					bits = 5'h00;
					zero_run--;
				end else begin
					pick = $urandom_range(0, 9);
					case (pick)
						0: begin
							// A run of misses long enough to arm the seek flag.
							bits     = 5'h00;
							zero_run = ((limit_now == 0) ? 16 : limit_now) - 1
								+ $urandom_range(0, 1);
						end
						1, 2: bits = 5'h00;
						3: bits = 5'($urandom_range(0, 15) << 1) | MASK_EDGE_RIGHT;
						4, 5: bits = 5'($urandom_range(1, 3) << 1);
						6, 7: bits = 5'($urandom_range(1, 3) << 3);
						default: bits = 5'($urandom_range(0, 31));
					endcase
				end
				if (ph == 2 && n == PHASE_ITEMS / 2)
					hold_until_drained();
				send_sample(bits, draw_gap(), 1'b0, 16'd0, 16'd0);
			end
		end

		// Wind down: wait for the last results, then keep watching for strays before the verdict.
		sensor_valid <= 1'b0;
		while (pending_compares.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES + 4) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/lfs_pkg.sv
src/lfs_frac.sv
src/lfs_core.sv
src/line_follow_steering_unit.sv
src/lfs_checker.sv
test/line_follow_steering_unit_tb.sv
